// File: sv/slbsw_pkg.sv
// ----------------------------------------------------------------------------
// slbsw_pkg
// Types and constants shared by the segment LCD buffer serial writer.
// ----------------------------------------------------------------------------
package slbsw_pkg;

  localparam int unsigned BufferBytesDef  = 16;
  localparam int unsigned AddressBitsDef  = 6;

  // Header bits and command frame length (header, 8 command bits, extra strobe)
  localparam int unsigned HeaderBits      = 3;
  localparam int unsigned CmdFrameBits    = 12;

  localparam logic [7:0]  PointMask       = 8'h80;
  localparam logic [7:0]  SegMask         = 8'h7F;

  typedef enum logic [2:0] {
    KIND_TICK    = 3'd0,
    KIND_SEGMENT = 3'd1,
    KIND_POINT   = 3'd2,
    KIND_FILL    = 3'd3,
    KIND_COMMAND = 3'd4,
    KIND_REFRESH = 3'd5
  } kind_e;

  // Write request to the segment memory: two lanes and a fill.
  typedef struct packed {
    logic seg_we;  // bits 6..0 of the addressed byte
    logic pnt_we;  // bit 7 of the addressed byte
    logic fill;    // every byte takes the write data
  } mem_wr_t;

  // One result item, chip select in the lowest bit.
  typedef struct packed {
    logic accepted;
    logic busy;
    logic data_pin;
    logic write_strobe_n;
    logic chip_select_n;
  } res_t;

endpackage

// File: sv/segment_lcd_buffer_serial_writer.sv
// ----------------------------------------------------------------------------
// segment_lcd_buffer_serial_writer
// Segment buffer with a three-wire serial writer: buffer updates, command
// frames and refresh frames, one strobe half per tick.
// ----------------------------------------------------------------------------
// Results are registered in the output skid stage before they are offered.
// Throughput: one item per cycle while the skid entry is free; each item is a single memory write or one
// step of the frame serializer, and the buffer byte for the next bit is
// prefetched through the memory's registered read port.
// Reset: pins idle high, not busy, buffer reads as all zero, no result held.
// ----------------------------------------------------------------------------
module segment_lcd_buffer_serial_writer #(
  parameter int unsigned BUFFER_BYTES = slbsw_pkg::BufferBytesDef,
  parameter int unsigned ADDRESS_BITS = slbsw_pkg::AddressBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // index[3:0], value[11:4], flag[12], zeros
  input  logic [2:0]  s_axis_tuser,   // kind[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // chip_select_n, write_strobe_n, data_pin,
                                      // busy_res, accepted, zeros
);
  import slbsw_pkg::*;

  localparam int unsigned AW       = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  localparam int unsigned HdrBits  = HeaderBits + ADDRESS_BITS;
  localparam int unsigned DataBits = HdrBits + 8 * BUFFER_BYTES;
  localparam int unsigned CW       = $clog2(DataBits + 1);

  logic          in_xfer;
  kind_e         kind;
  logic [3:0]    idx;
  logic [7:0]    value;
  logic          flag;
  logic          idx_ok;

  logic          busy_q, busy_d;
  logic          phase_q, phase_d;
  logic          is_data_q, is_data_d;
  logic [7:0]    cmd_q, cmd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          cs_q, cs_d;
  logic          wr_q, wr_d;
  logic          dat_q, dat_d;
  logic          accepted;
  logic [CW-1:0] total;
  logic          frame_bit;
  logic [CW-1:0] k_q, k_d, bpos;

  mem_wr_t       mem_wr;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_byte;
  res_t          res;
  res_t          out_res;

  assign in_xfer = s_axis_tvalid & s_axis_tready;
  assign kind    = kind_e'(s_axis_tuser);
  assign idx     = s_axis_tdata[3:0];
  assign value   = s_axis_tdata[11:4];
  assign flag    = s_axis_tdata[12];
  assign idx_ok  = {28'd0, idx} < BUFFER_BYTES;
  assign wr_addr = AW'(idx);
  assign total   = is_data_q ? CW'(DataBits) : CW'(CmdFrameBits);

  // Bit to drive at the current frame position.
  assign k_q = cnt_q - CW'(HdrBits);
  always_comb begin
    if (cnt_q < CW'(HeaderBits)) begin
      frame_bit = (cnt_q == '0) ? 1'b1 : ((cnt_q == CW'(1)) ? 1'b0 : is_data_q);
    end else if (!is_data_q) begin
      if (cnt_q < CW'(CmdFrameBits - 1)) begin
        frame_bit = cmd_q[3'(4'd10 - cnt_q[3:0])];
      end else begin
        // The extra command strobe keeps the last command bit on the data line.
        frame_bit = cmd_q[0];
      end
    end else if (cnt_q < CW'(HdrBits)) begin
      frame_bit = 1'b0;
    end else begin
      frame_bit = rd_byte[3'd7 - k_q[2:0]];
    end
  end

  always_comb begin
    busy_d    = busy_q;
    phase_d   = phase_q;
    is_data_d = is_data_q;
    cmd_d     = cmd_q;
    cnt_d     = cnt_q;
    cs_d      = cs_q;
    wr_d      = wr_q;
    dat_d     = dat_q;
    accepted  = 1'b0;
    mem_wr    = '0;
    wr_data   = value;
    if (in_xfer) begin
      if (kind == KIND_TICK) begin
        if (busy_q) begin
          if (cnt_q >= total) begin
            cs_d    = 1'b1;
            wr_d    = 1'b1;
            dat_d   = 1'b1;
            busy_d  = 1'b0;
            cnt_d   = '0;
            phase_d = 1'b0;
          end else if (!phase_q) begin
            cs_d    = 1'b0;
            wr_d    = 1'b0;
            dat_d   = frame_bit;
            phase_d = 1'b1;
          end else begin
            cs_d    = 1'b0;
            wr_d    = 1'b1;
            cnt_d   = cnt_q + CW'(1);
            phase_d = 1'b0;
          end
        end
      end else if (!busy_q) begin
        unique case (kind)
          KIND_SEGMENT: begin
            accepted      = 1'b1;
            mem_wr.seg_we = idx_ok;
          end
          KIND_POINT: begin
            accepted      = 1'b1;
            mem_wr.pnt_we = idx_ok;
            wr_data       = {flag, 7'd0};
          end
          KIND_FILL: begin
            accepted    = 1'b1;
            mem_wr.fill = 1'b1;
          end
          KIND_COMMAND, KIND_REFRESH: begin
            accepted  = 1'b1;
            is_data_d = (kind == KIND_REFRESH);
            if (kind == KIND_COMMAND) begin
              cmd_d = value;
            end
            cnt_d   = '0;
            phase_d = 1'b0;
            cs_d    = 1'b0;
            wr_d    = 1'b1;
            dat_d   = 1'b1;
            busy_d  = 1'b1;
          end
          default: begin
            accepted = 1'b0;
          end
        endcase
      end
    end
  end

  // Prefetch the byte for the next frame position; it is in the read register
  // by the time the following strobe-low half needs it.
  assign k_d  = cnt_d - CW'(HdrBits);
  assign bpos = k_d >> 3;
  always_comb begin
    if (cnt_d >= CW'(HdrBits) && bpos < CW'(BUFFER_BYTES)) begin
      rd_addr = AW'(CW'(BUFFER_BYTES - 1) - bpos);
    end else begin
      rd_addr = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      phase_q   <= 1'b0;
      is_data_q <= 1'b0;
      cmd_q     <= '0;
      cnt_q     <= '0;
      cs_q      <= 1'b1;
      wr_q      <= 1'b1;
      dat_q     <= 1'b1;
    end else begin
      busy_q    <= busy_d;
      phase_q   <= phase_d;
      is_data_q <= is_data_d;
      cmd_q     <= cmd_d;
      cnt_q     <= cnt_d;
      cs_q      <= cs_d;
      wr_q      <= wr_d;
      dat_q     <= dat_d;
    end
  end

  slbsw_seg_mem #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_seg_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (mem_wr),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_byte)
  );

  assign res.accepted       = accepted;
  assign res.busy           = busy_d;
  assign res.data_pin       = dat_d;
  assign res.write_strobe_n = wr_d;
  assign res.chip_select_n  = cs_d;

  slbsw_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_xfer),
    .push_data_i (res),
    .ready_o     (s_axis_tready),
    .valid_o     (m_axis_tvalid),
    .data_o      (out_res),
    .take_i      (m_axis_tready)
  );

  assign m_axis_tdata = {3'd0, out_res};

  // Idle means all three lines released.
  a_idle_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (cs_q && wr_q && dat_q))
    else $error("pins not idle while not busy");

  // The frame position never runs past the end of the frame.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q <= total))
    else $error("frame position beyond frame length");

  // A frame starts with chip select low and the strobe high.
  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> (!cs_q && wr_q && cnt_q == '0 && !phase_q))
    else $error("frame did not start cleanly");

  // Input is only held off while a result is waiting downstream.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

endmodule

// File: sv/slbsw_seg_mem.sv
// ----------------------------------------------------------------------------
// slbsw_seg_mem
// Segment byte memory with separate write lanes for the segment bits and the
// point bit, a registered read port, and a fill that works through per-lane
// valid bits, so that it needs no pass over the stored bytes.
// ----------------------------------------------------------------------------
module slbsw_seg_mem #(
  parameter int unsigned BUFFER_BYTES = slbsw_pkg::BufferBytesDef,
  localparam int unsigned AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  slbsw_pkg::mem_wr_t wr_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [7:0]        wr_data_i,
  input  logic [AW-1:0]     rd_addr_i,
  output logic [7:0]        rd_data_o
);
  import slbsw_pkg::*;

  logic [7:0]              mem [BUFFER_BYTES];
  logic [BUFFER_BYTES-1:0] seg_vld_q;
  logic [BUFFER_BYTES-1:0] pnt_vld_q;
  logic [7:0]              fill_q;
  logic [7:0]              rd_q;
  logic                    rd_seg_vld_q;
  logic                    rd_pnt_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.seg_we) begin
      mem[wr_addr_i][6:0] <= wr_data_i[6:0];
    end
    if (wr_i.pnt_we) begin
      mem[wr_addr_i][7] <= wr_data_i[7];
    end
    rd_q <= mem[rd_addr_i];
  end

  // An entry whose lane was not written since the last fill reads as the fill byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_vld_q    <= '0;
      pnt_vld_q    <= '0;
      fill_q       <= '0;
      rd_seg_vld_q <= 1'b0;
      rd_pnt_vld_q <= 1'b0;
    end else begin
      if (wr_i.fill) begin
        seg_vld_q <= '0;
        pnt_vld_q <= '0;
        fill_q    <= wr_data_i;
      end else begin
        if (wr_i.seg_we) begin
          seg_vld_q[wr_addr_i] <= 1'b1;
        end
        if (wr_i.pnt_we) begin
          pnt_vld_q[wr_addr_i] <= 1'b1;
        end
      end
      rd_seg_vld_q <= seg_vld_q[rd_addr_i];
      rd_pnt_vld_q <= pnt_vld_q[rd_addr_i];
    end
  end

  assign rd_data_o = ((rd_pnt_vld_q ? rd_q : fill_q) & PointMask)
                   | ((rd_seg_vld_q ? rd_q : fill_q) & SegMask);

endmodule

// File: sv/slbsw_skid.sv
// ----------------------------------------------------------------------------
// slbsw_skid
// Output register with a skid entry, so that an input transfer can be taken
// while the current result is still waiting for the downstream side.
// ----------------------------------------------------------------------------
module slbsw_skid (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  slbsw_pkg::res_t  push_data_i,
  output logic             ready_o,
  output logic             valid_o,
  output slbsw_pkg::res_t  data_o,
  input  logic             take_i
);
  import slbsw_pkg::*;

  logic out_vld_q, out_vld_d;
  logic skd_vld_q, skd_vld_d;
  res_t out_q, out_d;
  res_t skd_q, skd_d;
  logic drain;

  assign drain = out_vld_q & take_i;

  always_comb begin
    out_vld_d = out_vld_q;
    skd_vld_d = skd_vld_q;
    out_d     = out_q;
    skd_d     = skd_q;
    if (skd_vld_q) begin
      if (drain) begin
        out_d     = skd_q;
        skd_vld_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_vld_q || drain) begin
        out_d     = push_data_i;
        out_vld_d = 1'b1;
      end else begin
        skd_d     = push_data_i;
        skd_vld_d = 1'b1;
      end
    end else if (drain) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      skd_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      skd_vld_q <= skd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    skd_q <= skd_d;
  end

  assign ready_o = !skd_vld_q;
  assign valid_o = out_vld_q;
  assign data_o  = out_q;

endmodule

// File: verif/segment_lcd_buffer_serial_writer_test.sv
// ----------------------------------------------------------------------------
// segment_lcd_buffer_serial_writer_test
// Self-checking bench for the segment LCD buffer serial writer. A directed
// table covers idle and busy behaviour, the undefined kinds and buffer
// extremes. Random bursts of updates followed by complete command and
// refresh frames come after it. Every result is checked against a
// cycle-free model of the buffer and the serializer, under four idling
// regimes on the two streams.
// ----------------------------------------------------------------------------
module segment_lcd_buffer_serial_writer_test;
  import slbsw_pkg::*;

  localparam logic [2:0]  KindSpare6   = 3'd6;
  localparam logic [2:0]  KindSpare7   = 3'd7;
  localparam int unsigned RandomItems  = 1100;
  localparam int unsigned StallLimit   = 4000;
  localparam int unsigned TailCycles   = 4;
  localparam int unsigned MaxReports   = 10;

  // Result words that can be read straight off the pin rules:
  // {accepted, busy, data, strobe_n, cs_n}.
  localparam res_t ResIdle   = 5'b00111;
  localparam res_t ResUpdate = 5'b10111;
  localparam res_t ResStart  = 5'b11110;
  localparam res_t ResHeld   = 5'b01110;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;   // index[3:0], value[11:4], flag[12], zeros
  logic [2:0]  s_axis_tuser  = KIND_TICK;  // kind[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [7:0]  m_axis_tdata;         // cs_n, strobe_n, data, busy, accepted, zeros

  segment_lcd_buffer_serial_writer u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the buffer and the serializer
  // ---------------------------------------------------------------------------
  logic [7:0]  lcd_mem [BufferBytesDef];
  int unsigned frame_pos;
  bit          strobe_high;
  bit          frame_data;
  logic [7:0]  cmd_code;
  logic        pin_cs, pin_wr, pin_data;
  bit          lcd_busy;

  int unsigned updates_taken, cmd_frames, refresh_frames, serial_ticks;
  int unsigned ignored_items, useful_items;

  res_t        expected_pins [$];
  int unsigned results_seen, mismatches;
  int unsigned send_idle_pct, recv_stall_pct;

  function automatic logic frame_bit_at(int unsigned n);
    int unsigned k;
    if (n == 0) return 1'b1;
    if (n == 1) return 1'b0;
    if (n == 2) return frame_data;
    if (!frame_data) begin
      // The trailing strobe repeats the last command bit.
      if (n < HeaderBits + 8) return cmd_code[7 - (n - HeaderBits)];
      return cmd_code[0];
    end
    if (n < HeaderBits + AddressBitsDef) return 1'b0;
    k = n - HeaderBits - AddressBitsDef;
    if (k / 8 >= BufferBytesDef) return 1'b0;
    return lcd_mem[BufferBytesDef - 1 - k / 8][7 - k % 8];
  endfunction

  function automatic res_t lcd_step(logic [2:0] kind, logic [3:0] index,
                                    logic [7:0] value, logic flag);
    res_t        r;
    bit          taken;
    int unsigned len;
    taken = 1'b0;
    len = frame_data ? HeaderBits + AddressBitsDef + 8 * BufferBytesDef : CmdFrameBits;
    if (kind == KIND_TICK) begin
      if (lcd_busy) begin
        serial_ticks++;
        useful_items++;
        if (frame_pos >= len) begin
          {pin_cs, pin_wr, pin_data} = 3'b111;
          lcd_busy    = 1'b0;
          frame_pos   = 0;
          strobe_high = 1'b0;
        end else if (!strobe_high) begin
          {pin_cs, pin_wr} = 2'b00;
          pin_data    = frame_bit_at(frame_pos);
          strobe_high = 1'b1;
        end else begin
          {pin_cs, pin_wr} = 2'b01;
          frame_pos++;
          strobe_high = 1'b0;
        end
      end
    end else if (!lcd_busy && kind <= KIND_REFRESH) begin
      taken = 1'b1;
      useful_items++;
      case (kind)
        KIND_SEGMENT: begin
          updates_taken++;
          if (index < BufferBytesDef)
            lcd_mem[index] = (lcd_mem[index] & PointMask) | (value & SegMask);
        end
        KIND_POINT: begin
          updates_taken++;
          if (index < BufferBytesDef)
            lcd_mem[index] = flag ? (lcd_mem[index] | PointMask)
                                  : (lcd_mem[index] & SegMask);
        end
        KIND_FILL: begin
          updates_taken++;
          foreach (lcd_mem[i]) lcd_mem[i] = value;
        end
        default: begin
          frame_data = (kind == KIND_REFRESH);
          if (kind == KIND_COMMAND) begin
            cmd_code = value;
            cmd_frames++;
          end else begin
            refresh_frames++;
          end
          frame_pos   = 0;
          strobe_high = 1'b0;
          {pin_cs, pin_wr, pin_data} = 3'b011;
          lcd_busy    = 1'b1;
        end
      endcase
    end else begin
      if (kind != KIND_TICK) ignored_items++;
    end
    r.chip_select_n  = pin_cs;
    r.write_strobe_n = pin_wr;
    r.data_pin       = pin_data;
    r.busy           = lcd_busy;
    r.accepted       = taken;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [2:0] kind, input logic [3:0] index,
                           input logic [7:0] value, input logic flag,
                           input bit known = 1'b0, input res_t known_res = '0);
    res_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {3'b000, flag, value, index};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = lcd_step(kind, index, value, flag);
    expected_pins.push_back(known ? known_res : predicted);
    @(negedge clk_i);
  endtask

  task automatic send_random_update();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)
      send_item(KIND_SEGMENT, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
    else if (pick < 85)
      send_item(KIND_POINT, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
    else
      send_item(KIND_FILL, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
  endtask

  // Any kind at all, the undefined ones included, with random fields.
  task automatic send_noise();
    send_item(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // A handful of buffer updates, then usually a frame clocked out to the end.
  task automatic random_burst();
    int unsigned n;
    int unsigned roll;
    n = $urandom_range(0, 5);
    repeat (n) begin
      if ($urandom_range(0, 99) < 12) send_noise();
      else send_random_update();
    end
    roll = $urandom_range(0, 99);
    if (roll < 8) return;
    send_item(roll < 28 ? KIND_REFRESH : KIND_COMMAND, 4'($urandom_range(0, 15)),
              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    while (lcd_busy) begin
      if ($urandom_range(0, 99) < 6) send_noise();
      else send_item(KIND_TICK, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [2:0]  kind;
    logic [3:0]  index;
    logic [7:0]  value;
    logic        flag;
    int unsigned reps;
    bit          known;
    res_t        want;
  } stim_row_t;

  localparam int unsigned DirectedRows = 18;

  stim_row_t directed_rows [DirectedRows] = '{
    '{KIND_TICK,    4'd0,  8'h00, 1'b0, 1,  1'b1, ResIdle},    // tick while idle
    '{KindSpare6,   4'd15, 8'hFF, 1'b1, 1,  1'b1, ResIdle},
    '{KindSpare7,   4'd0,  8'h00, 1'b0, 1,  1'b1, ResIdle},
    '{KIND_FILL,    4'd0,  8'h00, 1'b0, 1,  1'b1, ResUpdate},
    '{KIND_SEGMENT, 4'd15, 8'hFF, 1'b0, 1,  1'b1, ResUpdate},  // bit 7 dropped
    '{KIND_POINT,   4'd15, 8'h00, 1'b1, 1,  1'b1, ResUpdate},
    '{KIND_POINT,   4'd0,  8'hFF, 1'b1, 1,  1'b1, ResUpdate},
    '{KIND_SEGMENT, 4'd0,  8'h00, 1'b0, 1,  1'b1, ResUpdate},  // point bit kept
    '{KIND_POINT,   4'd15, 8'hFF, 1'b0, 1,  1'b1, ResUpdate},
    '{KIND_COMMAND, 4'd0,  8'h81, 1'b0, 1,  1'b1, ResStart},
    '{KIND_SEGMENT, 4'd2,  8'h55, 1'b1, 1,  1'b1, ResHeld},    // ignored while busy
    '{KIND_REFRESH, 4'd0,  8'h00, 1'b0, 1,  1'b1, ResHeld},
    '{KindSpare7,   4'd0,  8'h00, 1'b0, 1,  1'b1, ResHeld},
    '{KIND_TICK,    4'd0,  8'h00, 1'b0, 25, 1'b0, ResIdle},    // whole command frame
    '{KIND_TICK,    4'd15, 8'hFF, 1'b1, 1,  1'b1, ResIdle},
    '{KIND_COMMAND, 4'd0,  8'h7E, 1'b0, 1,  1'b1, ResStart},
    '{KIND_TICK,    4'd9,  8'hA5, 1'b1, 25, 1'b0, ResIdle},
    '{KIND_FILL,    4'd0,  8'hFF, 1'b0, 1,  1'b1, ResUpdate}
  };

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic note_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    mismatches++;
    if (mismatches <= MaxReports)
      $display("result %0d, %s: expected %0d, got %0d", results_seen, what, want, got);
  endtask

  always @(posedge clk_i) begin : result_check
    res_t want;
    res_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = res_t'(m_axis_tdata[4:0]);
      results_seen++;
      if (expected_pins.size() == 0) begin
        note_mismatch("transfer with nothing expected", 0, 1);
      end else begin
        want = expected_pins.pop_front();
        if (got.chip_select_n != want.chip_select_n)
          note_mismatch("chip_select_n", 32'(want.chip_select_n), 32'(got.chip_select_n));
        if (got.write_strobe_n != want.write_strobe_n)
          note_mismatch("write_strobe_n", 32'(want.write_strobe_n),
                        32'(got.write_strobe_n));
        if (got.data_pin != want.data_pin)
          note_mismatch("data_pin", 32'(want.data_pin), 32'(got.data_pin));
        if (got.busy != want.busy)
          note_mismatch("busy", 32'(want.busy), 32'(got.busy));
        if (got.accepted != want.accepted)
          note_mismatch("accepted", 32'(want.accepted), 32'(got.accepted));
        if (m_axis_tdata[7:5] != 3'b000)
          note_mismatch("padding", 0, 32'(m_axis_tdata[7:5]));
      end
    end
  end

  // Ends the run when neither stream has moved a transfer for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL segment_lcd_buffer_serial_writer");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned goal;
    foreach (lcd_mem[i]) lcd_mem[i] = 8'h00;
    frame_pos   = 0;
    strobe_high = 1'b0;
    frame_data  = 1'b0;
    cmd_code    = 8'h00;
    {pin_cs, pin_wr, pin_data} = 3'b111;
    lcd_busy    = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[r]) begin
      repeat (directed_rows[r].reps)
        send_item(directed_rows[r].kind, directed_rows[r].index, directed_rows[r].value,
                  directed_rows[r].flag, directed_rows[r].known, directed_rows[r].want);
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      goal = useful_items + RandomItems / 4;
      while (useful_items < goal) random_burst();
      // Hold the input off until every outstanding result has drained.
      s_axis_tvalid <= 1'b0;
      while (expected_pins.size() != 0) @(posedge clk_i);
      @(negedge clk_i);
    end

    repeat (TailCycles) @(posedge clk_i);
    $display("Checked %0d results: %0d buffer updates, %0d command and %0d refresh frames,",
             results_seen, updates_taken, cmd_frames, refresh_frames);
    $display("%0d serializer ticks and %0d items dropped while busy or undefined.",
             serial_ticks, ignored_items);
    if (mismatches == 0 && expected_pins.size() == 0) begin
      $display("PASS segment_lcd_buffer_serial_writer");
    end else begin
      $display("FAIL segment_lcd_buffer_serial_writer");
    end
    $finish;
  end

endmodule
